// ===== rtl/jsu_pkg.sv =====
// ----------------------------------------------------------------------------
// jsu_pkg: shared types for the JSON string unescaper
// Result kinds, error codes and the job word passed from front to back.
// ----------------------------------------------------------------------------
package jsu_pkg;

  typedef enum logic [1:0] {
    KIND_DATA  = 2'd0,
    KIND_DONE  = 2'd1,
    KIND_ERROR = 2'd2
  } kind_t;

  typedef enum logic [3:0] {
    ERR_NONE        = 4'd0,
    ERR_EOF_STRING  = 4'd1,
    ERR_EOF_HEX     = 4'd2,
    ERR_BAD_HEX     = 4'd3,
    ERR_BAD_ESCAPE  = 4'd4,
    ERR_CONTROL     = 4'd5,
    ERR_LOW_MISSING = 4'd6,
    ERR_BAD_LOW     = 4'd7,
    ERR_ORPHAN_LOW  = 4'd8
  } err_t;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // One job: either a single result word, or a code point to expand in UTF-8.
  typedef struct packed {
    logic        is_cp;
    logic [20:0] cp;
    logic [7:0]  data;
    kind_t       kind;
    err_t        code;
  } job_t;

endpackage

// ===== rtl/jsu_if.sv =====
// ----------------------------------------------------------------------------
// jsu_in_if / jsu_out_if: valid/ready channels of the unescaper
// Input carries one raw string byte; output carries one result word.
// ----------------------------------------------------------------------------
interface jsu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_input;

  modport source (output valid, output in_byte, output end_of_input, input ready);
  modport sink   (input valid, input in_byte, input end_of_input, output ready);
endinterface

interface jsu_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [1:0] result_kind;
  logic [3:0] error_code;
  logic       last;

  modport source (output valid, output out_byte, output result_kind,
                  output error_code, output last, input ready);
  modport sink   (input valid, input out_byte, input result_kind,
                  input error_code, input last, output ready);
endinterface

// ===== rtl/jsu_front.sv =====
// ----------------------------------------------------------------------------
// jsu_front: string body parser
// Takes one byte per cycle while the job queue has room, tracks escape state and pushes one job per result.
// ----------------------------------------------------------------------------
module jsu_front (
  input  logic          clk,
  input  logic          rst_n,
  jsu_in_if.sink        in_ch,
  input  logic          q_full,
  output logic          q_push,
  output jsu_pkg::job_t q_job
);
  import jsu_pkg::*;

  typedef enum logic [5:0] {
    MODE_PLAIN   = 6'b000001,
    MODE_ESC     = 6'b000010,
    MODE_HEX1    = 6'b000100,
    MODE_WANT_BS = 6'b001000,
    MODE_WANT_U  = 6'b010000,
    MODE_HEX2    = 6'b100000
  } mode_t;

  mode_t       mode_r, mode_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic [11:0] acc_r, acc_nxt;
  logic [9:0]  high_r, high_nxt;

  logic        accept;
  logic        job_vld;
  job_t        job;
  logic [4:0]  hex_d;
  logic [15:0] acc_full;
  logic [7:0]  b;

  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] v;
    v = 5'd16;
    if (c >= 8'h30 && c <= 8'h39) v = 5'(c - 8'h30);
    else if (c >= 8'h61 && c <= 8'h66) v = 5'(c - 8'h61 + 8'd10);
    else if (c >= 8'h41 && c <= 8'h46) v = 5'(c - 8'h41 + 8'd10);
    return v;
  endfunction

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign b           = in_ch.in_byte;
  assign hex_d       = hex_value(b);
  assign acc_full    = {acc_r, hex_d[3:0]};

  always_comb begin
    mode_nxt  = mode_r;
    cnt_nxt   = cnt_r;
    acc_nxt   = acc_r;
    high_nxt  = high_r;
    job_vld   = 1'b0;
    job.is_cp = 1'b0;
    job.cp    = 21'd0;
    job.data  = 8'd0;
    job.kind  = KIND_DATA;
    job.code  = ERR_NONE;

    if (in_ch.end_of_input) begin
      job_vld  = 1'b1;
      job.kind = KIND_ERROR;
      case (mode_r)
        MODE_HEX1, MODE_HEX2:      job.code = ERR_EOF_HEX;
        MODE_WANT_BS, MODE_WANT_U: job.code = ERR_LOW_MISSING;
        default:                   job.code = ERR_EOF_STRING;
      endcase
    end else begin
      case (mode_r)
        MODE_ESC: begin
          job_vld  = 1'b1;
          mode_nxt = MODE_PLAIN;
          case (b)
            8'h5C, 8'h2F, 8'h22: job.data = b;
            8'h62: job.data = 8'h08;
            8'h66: job.data = 8'h0C;
            8'h6E: job.data = 8'h0A;
            8'h72: job.data = 8'h0D;
            8'h74: job.data = 8'h09;
            8'h75: begin
              job_vld  = 1'b0;
              mode_nxt = MODE_HEX1;
              cnt_nxt  = 2'd0;
              acc_nxt  = 12'd0;
            end
            default: begin
              job.data = b;
              job.kind = KIND_ERROR;
              job.code = ERR_BAD_ESCAPE;
            end
          endcase
        end
        MODE_HEX1, MODE_HEX2: begin
          if (hex_d[4]) begin
            job_vld  = 1'b1;
            job.data = b;
            job.kind = KIND_ERROR;
            job.code = ERR_BAD_HEX;
          end else if (cnt_r != 2'd3) begin
            acc_nxt = acc_full[11:0];
            cnt_nxt = cnt_r + 2'd1;
          end else begin
            cnt_nxt = 2'd0;
            acc_nxt = 12'd0;
            if (mode_r == MODE_HEX1) begin
              if (acc_full[15:10] == 6'b110110) begin
                high_nxt = acc_full[9:0];
                mode_nxt = MODE_WANT_BS;
              end else if (acc_full[15:10] == 6'b110111) begin
                job_vld  = 1'b1;
                job.data = b;
                job.kind = KIND_ERROR;
                job.code = ERR_ORPHAN_LOW;
              end else begin
                job_vld   = 1'b1;
                job.is_cp = 1'b1;
                job.cp    = {5'd0, acc_full};
                mode_nxt  = MODE_PLAIN;
              end
            end else begin
              job_vld = 1'b1;
              if (acc_full[15:10] != 6'b110111) begin
                job.data = b;
                job.kind = KIND_ERROR;
                job.code = ERR_BAD_LOW;
              end else begin
                job.is_cp = 1'b1;
                job.cp    = {1'b0, high_r, acc_full[9:0]} + 21'h010000;
              end
            end
          end
        end
        MODE_WANT_BS: begin
          if (b == 8'h5C) mode_nxt = MODE_WANT_U;
          else begin
            job_vld  = 1'b1;
            job.data = b;
            job.kind = KIND_ERROR;
            job.code = ERR_LOW_MISSING;
          end
        end
        MODE_WANT_U: begin
          if (b == 8'h75) begin
            mode_nxt = MODE_HEX2;
            cnt_nxt  = 2'd0;
            acc_nxt  = 12'd0;
          end else begin
            job_vld  = 1'b1;
            job.data = b;
            job.kind = KIND_ERROR;
            job.code = ERR_LOW_MISSING;
          end
        end
        default: begin
          if (b == 8'h22) begin
            job_vld  = 1'b1;
            job.kind = KIND_DONE;
          end else if (b == 8'h5C) begin
            mode_nxt = MODE_ESC;
          end else if (b < 8'h20) begin
            job_vld  = 1'b1;
            job.data = b;
            job.kind = KIND_ERROR;
            job.code = ERR_CONTROL;
          end else begin
            job_vld  = 1'b1;
            job.data = b;
          end
        end
      endcase
    end

    // closing quote, errors and a finished surrogate pair drop all state
    if ((job_vld && job.kind != KIND_DATA) || (mode_r == MODE_HEX2 && job_vld)) begin
      mode_nxt = MODE_PLAIN;
      cnt_nxt  = 2'd0;
      acc_nxt  = 12'd0;
      high_nxt = 10'd0;
    end
  end

  assign q_push = accept && job_vld;
  assign q_job  = job;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_PLAIN;
      cnt_r  <= 2'd0;
      acc_r  <= 12'd0;
      high_r <= 10'd0;
    end else if (accept) begin
      mode_r <= mode_nxt;
      cnt_r  <= cnt_nxt;
      acc_r  <= acc_nxt;
      high_r <= high_nxt;
    end
  end

endmodule

// ===== rtl/jsu_queue.sv =====
// ----------------------------------------------------------------------------
// jsu_queue: job queue between parser and result expander
// Small register FIFO; full and empty come straight from the fill count.
// ----------------------------------------------------------------------------
module jsu_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  jsu_pkg::job_t push_job,
  output logic          full,
  input  logic          pop,
  output logic          nonempty,
  output jsu_pkg::job_t pop_job
);
  import jsu_pkg::*;

  job_t                  mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]     wr_r, wr_nxt;
  logic [QPTR_W-1:0]     rd_r, rd_nxt;
  logic [QPTR_W:0]       cnt_r, cnt_nxt;
  logic                  do_push, do_pop;

  assign full     = (cnt_r == (QPTR_W+1)'(QUEUE_DEPTH));
  assign nonempty = (cnt_r != '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && nonempty;
  assign pop_job  = mem_r[rd_r];

  always_comb begin
    wr_nxt  = do_push ? QPTR_W'(wr_r + 1'b1) : wr_r;
    rd_nxt  = do_pop  ? QPTR_W'(rd_r + 1'b1) : rd_r;
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) cnt_nxt = cnt_r + 1'b1;
    else if (!do_push && do_pop) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_r] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// ===== rtl/jsu_back.sv =====
// ----------------------------------------------------------------------------
// jsu_back: result expander
// Holds one job and walks it out as one to four result words.
// ----------------------------------------------------------------------------
module jsu_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_nonempty,
  input  jsu_pkg::job_t q_job,
  output logic          q_pop,
  jsu_out_if.source     out_ch
);
  import jsu_pkg::*;

  job_t       cur_r;
  logic       cur_vld_r, cur_vld_nxt;
  logic [1:0] idx_r, idx_nxt;
  logic [1:0] last_idx;
  logic [7:0] utf_byte;
  logic       out_acc;
  logic       take;

  // number of UTF-8 bytes minus one
  always_comb begin
    if (!cur_r.is_cp)              last_idx = 2'd0;
    else if (cur_r.cp < 21'h80)    last_idx = 2'd0;
    else if (cur_r.cp < 21'h800)   last_idx = 2'd1;
    else if (cur_r.cp < 21'h10000) last_idx = 2'd2;
    else                           last_idx = 2'd3;
  end

  always_comb begin
    utf_byte = cur_r.cp[7:0];
    case (last_idx)
      2'd1: utf_byte = (idx_r == 2'd0) ? {3'b110, cur_r.cp[10:6]} : {2'b10, cur_r.cp[5:0]};
      2'd2: begin
        case (idx_r)
          2'd0:    utf_byte = {4'b1110, cur_r.cp[15:12]};
          2'd1:    utf_byte = {2'b10, cur_r.cp[11:6]};
          default: utf_byte = {2'b10, cur_r.cp[5:0]};
        endcase
      end
      2'd3: begin
        case (idx_r)
          2'd0:    utf_byte = {5'b11110, cur_r.cp[20:18]};
          2'd1:    utf_byte = {2'b10, cur_r.cp[17:12]};
          2'd2:    utf_byte = {2'b10, cur_r.cp[11:6]};
          default: utf_byte = {2'b10, cur_r.cp[5:0]};
        endcase
      end
      default: utf_byte = cur_r.cp[7:0];
    endcase
  end

  assign out_ch.valid       = cur_vld_r;
  assign out_ch.out_byte    = cur_r.is_cp ? utf_byte : cur_r.data;
  assign out_ch.result_kind = cur_r.kind;
  assign out_ch.error_code  = cur_r.code;
  assign out_ch.last        = (idx_r == last_idx);

  assign out_acc = out_ch.valid && out_ch.ready;
  // load the next job once the current one has sent its last word
  assign take    = !cur_vld_r || (out_acc && out_ch.last);
  assign q_pop   = take && q_nonempty;

  always_comb begin
    cur_vld_nxt = cur_vld_r;
    idx_nxt     = idx_r;
    if (take) begin
      cur_vld_nxt = q_nonempty;
      idx_nxt     = 2'd0;
    end else if (out_acc) begin
      idx_nxt = idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) cur_r <= q_job;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_vld_r <= 1'b0;
      idx_r     <= 2'd0;
    end else begin
      cur_vld_r <= cur_vld_nxt;
      idx_r     <= idx_nxt;
    end
  end

endmodule

// ===== rtl/json_string_unescape_utf8.sv =====
// ----------------------------------------------------------------------------
// json_string_unescape_utf8: JSON string body unescaper with UTF-8 output
// Feed the bytes after the opening quote on in_ch, one byte per word; set
// end_of_input on a word that carries no byte to close the stream.
// Results leave on out_ch: data bytes, a finished word at the closing quote,
// or one error word. last marks the final word caused by one input byte.
// Throughput: one input byte per cycle while the job queue has room. Bytes
// that decode to one result sustain one word per cycle while out_ch is ready;
// a \u escape yields its one to four UTF-8 bytes, one word per cycle.
// Results pass through the four-entry job queue and then the expander's job
// register before they leave on out_ch.
// Escape bytes and leading hex digits produce no words.
// Reset (rst_n low, synchronous) empties the queue and returns the parser to
// the string body. When out_ch stalls, words hold; the parser keeps taking
// bytes until the job queue fills, then drops in_ch.ready.
// ----------------------------------------------------------------------------
module json_string_unescape_utf8 (
  input  logic      clk,
  input  logic      rst_n,
  jsu_in_if.sink    in_ch,
  jsu_out_if.source out_ch
);
  import jsu_pkg::*;

  logic q_full;
  logic q_push;
  logic q_pop;
  logic q_nonempty;
  job_t push_job;
  job_t pop_job;

  jsu_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .q_full (q_full),
    .q_push (q_push),
    .q_job  (push_job)
  );

  jsu_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (q_pop),
    .nonempty (q_nonempty),
    .pop_job  (pop_job)
  );

  jsu_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_nonempty (q_nonempty),
    .q_job      (pop_job),
    .q_pop      (q_pop),
    .out_ch     (out_ch)
  );

endmodule

// ===== dv/json_string_unescape_utf8_tb.sv =====
// ----------------------------------------------------------------------------
// json_string_unescape_utf8_tb: self-checking bench for the JSON unescaper
// Streams string-body bytes through the input channel with bursty timing and
// a stalling receiver. Every accepted byte runs through a local decoder that
// builds the expected result words, UTF-8 expansion included. The monitor
// compares each word leaving the block, field by field, in order.
// ----------------------------------------------------------------------------
module json_string_unescape_utf8_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import jsu_pkg::*;

  localparam int unsigned RANDOM_ITEMS     = 420;
  localparam int unsigned LONG_HOLD_START  = 400;
  localparam int unsigned LONG_HOLD_CYCLES = 150;
  localparam int unsigned DRAIN_CYCLES     = 12;

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_U      = 8'h75;

  typedef enum logic [2:0] {
    PM_BODY     = 3'd0,
    PM_ESC      = 3'd1,
    PM_HEX_HI   = 3'd2,
    PM_WANT_BSL = 3'd3,
    PM_WANT_U   = 3'd4,
    PM_HEX_LO   = 3'd5
  } parse_mode_t;

  typedef enum int {
    RX_OPEN,
    RX_LIGHT,
    RX_HEAVY,
    RX_PERIODIC
  } rx_pattern_t;

  typedef struct {
    logic [7:0] data;
    logic       eof;
  } in_word_t;

  typedef struct {
    logic [7:0] data;
    kind_t      kind;
    err_t       code;
    logic       last;
  } result_word_t;

  logic clk;
  logic rst_n = 1'b0;

  jsu_in_if  in_ch ();
  jsu_out_if out_ch ();

  json_string_unescape_utf8 dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  in_word_t     pending_bytes[$];
  result_word_t exp_words[$];
  int unsigned  items_queued   = 0;
  int unsigned  mismatch_count = 0;

  // decoder state
  parse_mode_t pmode   = PM_BODY;
  logic [1:0]  hex_cnt = '0;
  logic [15:0] hex_acc = '0;
  logic [9:0]  hi_half = '0;

  // sender and receiver timing
  in_word_t     drv_next;
  int unsigned  burst_left, gap_left;
  int unsigned  rx_cycle, pattern_left, long_hold_left;
  rx_pattern_t  stall_pattern;
  logic         rx_ready;
  result_word_t got_exp;

  initial begin
    clk                = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.in_byte      = '0;
    in_ch.end_of_input = 1'b0;
    out_ch.ready       = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
  end

  initial begin
    #2000000;
    $display("** json_string_unescape_utf8: FAILED **");
    $finish;
  end

  // --------------------------------------------------------------------------
  // decoder
  // --------------------------------------------------------------------------
  function automatic logic [4:0] hex_nibble(input logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return 5'(c - 8'h30);
    if (c >= 8'h61 && c <= 8'h66) return 5'(c - 8'h61 + 8'd10);
    if (c >= 8'h41 && c <= 8'h46) return 5'(c - 8'h41 + 8'd10);
    return 5'd16;
  endfunction

  task automatic push_word(input logic [7:0] b, input kind_t k, input err_t c);
    result_word_t w;
    w.data = b;
    w.kind = k;
    w.code = c;
    w.last = 1'b0;
    exp_words.push_back(w);
  endtask

  task automatic clear_decoder();
    pmode   = PM_BODY;
    hex_cnt = '0;
    hex_acc = '0;
    hi_half = '0;
  endtask

  task automatic raise_error(input logic [7:0] b, input err_t c);
    clear_decoder();
    push_word(b, KIND_ERROR, c);
  endtask

  task automatic emit_utf8(input logic [20:0] cp);
    if (cp < 21'h80) begin
      push_word(cp[7:0], KIND_DATA, ERR_NONE);
    end else if (cp < 21'h800) begin
      push_word({3'b110, cp[10:6]}, KIND_DATA, ERR_NONE);
      push_word({2'b10, cp[5:0]}, KIND_DATA, ERR_NONE);
    end else if (cp < 21'h10000) begin
      push_word({4'b1110, cp[15:12]}, KIND_DATA, ERR_NONE);
      push_word({2'b10, cp[11:6]}, KIND_DATA, ERR_NONE);
      push_word({2'b10, cp[5:0]}, KIND_DATA, ERR_NONE);
    end else begin
      push_word({5'b11110, cp[20:18]}, KIND_DATA, ERR_NONE);
      push_word({2'b10, cp[17:12]}, KIND_DATA, ERR_NONE);
      push_word({2'b10, cp[11:6]}, KIND_DATA, ERR_NONE);
      push_word({2'b10, cp[5:0]}, KIND_DATA, ERR_NONE);
    end
  endtask

  task automatic unescape_step(input logic [7:0] b, input logic eof);
    int unsigned n0;
    logic [4:0]  dig;
    logic [15:0] acc;
    logic [20:0] cp;
    n0 = exp_words.size();
    if (eof) begin
      case (pmode)
        PM_HEX_HI, PM_HEX_LO:   raise_error(8'h00, ERR_EOF_HEX);
        PM_WANT_BSL, PM_WANT_U: raise_error(8'h00, ERR_LOW_MISSING);
        default:                raise_error(8'h00, ERR_EOF_STRING);
      endcase
    end else begin
      case (pmode)
        PM_ESC: begin
          case (b)
            CH_BSLASH, CH_SLASH, CH_QUOTE: begin
              pmode = PM_BODY;
              push_word(b, KIND_DATA, ERR_NONE);
            end
            CH_B: begin pmode = PM_BODY; push_word(8'h08, KIND_DATA, ERR_NONE); end
            CH_F: begin pmode = PM_BODY; push_word(8'h0C, KIND_DATA, ERR_NONE); end
            CH_N: begin pmode = PM_BODY; push_word(8'h0A, KIND_DATA, ERR_NONE); end
            CH_R: begin pmode = PM_BODY; push_word(8'h0D, KIND_DATA, ERR_NONE); end
            CH_T: begin pmode = PM_BODY; push_word(8'h09, KIND_DATA, ERR_NONE); end
            CH_U: begin
              pmode   = PM_HEX_HI;
              hex_cnt = '0;
              hex_acc = '0;
            end
            default: raise_error(b, ERR_BAD_ESCAPE);
          endcase
        end
        PM_HEX_HI, PM_HEX_LO: begin
          dig = hex_nibble(b);
          if (dig[4]) begin
            raise_error(b, ERR_BAD_HEX);
          end else begin
            acc = {hex_acc[11:0], dig[3:0]};
            if (hex_cnt != 2'd3) begin
              hex_acc = acc;
              hex_cnt = hex_cnt + 2'd1;
            end else begin
              hex_cnt = '0;
              hex_acc = '0;
              if (pmode == PM_HEX_HI) begin
                if (acc[15:10] == 6'b110110) begin
                  hi_half = acc[9:0];
                  pmode   = PM_WANT_BSL;
                end else if (acc[15:10] == 6'b110111) begin
                  raise_error(b, ERR_ORPHAN_LOW);
                end else begin
                  pmode = PM_BODY;
                  emit_utf8({5'd0, acc});
                end
              end else if (acc[15:10] != 6'b110111) begin
                raise_error(b, ERR_BAD_LOW);
              end else begin
                cp = {1'b0, hi_half, acc[9:0]} + 21'h10000;
                clear_decoder();
                emit_utf8(cp);
              end
            end
          end
        end
        PM_WANT_BSL: begin
          if (b != CH_BSLASH) raise_error(b, ERR_LOW_MISSING);
          else pmode = PM_WANT_U;
        end
        PM_WANT_U: begin
          if (b != CH_U) begin
            raise_error(b, ERR_LOW_MISSING);
          end else begin
            pmode   = PM_HEX_LO;
            hex_cnt = '0;
            hex_acc = '0;
          end
        end
        default: begin
          if (b == CH_QUOTE) begin
            clear_decoder();
            push_word(8'h00, KIND_DONE, ERR_NONE);
          end else if (b == CH_BSLASH) begin
            pmode = PM_ESC;
          end else if (b < 8'h20) begin
            raise_error(b, ERR_CONTROL);
          end else begin
            pmode = PM_BODY;
            push_word(b, KIND_DATA, ERR_NONE);
          end
        end
      endcase
    end
    if (exp_words.size() > n0) exp_words[exp_words.size() - 1].last = 1'b1;
  endtask

  // --------------------------------------------------------------------------
  // stimulus
  // --------------------------------------------------------------------------
  task automatic queue_byte(input logic [7:0] b, input logic eof);
    in_word_t w;
    w.data = b;
    w.eof  = eof;
    pending_bytes.push_back(w);
    items_queued++;
  endtask

  // push the leading n hex digits of v, letters in random case
  task automatic queue_hex(input logic [15:0] v, input int unsigned n);
    logic [3:0] d;
    for (int i = 0; i < n; i++) begin
      d = v[15 - 4 * i -: 4];
      if (d < 4'd10) queue_byte(8'h30 + d, 1'b0);
      else queue_byte((($urandom_range(0, 1) != 0) ? 8'h61 : 8'h41) + d - 8'd10, 1'b0);
    end
  endtask

  task automatic queue_escape_u(input logic [15:0] v);
    queue_byte(CH_BSLASH, 1'b0);
    queue_byte(CH_U, 1'b0);
    queue_hex(v, 4);
  endtask

  task automatic queue_random_sequence();
    int unsigned sel, n;
    logic [7:0]  b;
    logic [15:0] v;
    sel = $urandom_range(0, 99);
    if (sel < 40) begin
      n = $urandom_range(1, 6);
      repeat (n) begin
        do b = 8'($urandom_range(8'h20, 8'hFF)); while (b == CH_QUOTE || b == CH_BSLASH);
        queue_byte(b, 1'b0);
      end
    end else if (sel < 50) begin
      queue_byte(CH_BSLASH, 1'b0);
      case ($urandom_range(0, 7))
        0: queue_byte(CH_QUOTE, 1'b0);
        1: queue_byte(CH_BSLASH, 1'b0);
        2: queue_byte(CH_SLASH, 1'b0);
        3: queue_byte(CH_B, 1'b0);
        4: queue_byte(CH_F, 1'b0);
        5: queue_byte(CH_N, 1'b0);
        6: queue_byte(CH_R, 1'b0);
        default: queue_byte(CH_T, 1'b0);
      endcase
    end else if (sel < 65) begin
      case ($urandom_range(0, 2))
        0: v = 16'($urandom_range(0, 16'h7F));
        1: v = 16'($urandom_range(16'h80, 16'h7FF));
        default: do v = 16'($urandom_range(16'h800, 16'hFFFF)); while (v[15:11] == 5'b11011);
      endcase
      queue_escape_u(v);
    end else if (sel < 75) begin
      queue_escape_u(16'hD800 | 16'($urandom_range(0, 1023)));
      queue_escape_u(16'hDC00 | 16'($urandom_range(0, 1023)));
    end else if (sel < 80) begin
      queue_byte(CH_QUOTE, 1'b0);
    end else if (sel < 83 || sel >= 95) begin
      queue_byte(8'($urandom_range(0, 255)), 1'b0);
    end else if (sel == 83) begin
      queue_byte(8'($urandom_range(0, 8'h1F)), 1'b0);
    end else if (sel == 84) begin
      queue_byte(CH_BSLASH, 1'b0);
      do b = 8'($urandom_range(0, 255));
      while (b inside {CH_QUOTE, CH_BSLASH, CH_SLASH, CH_B, CH_F, CH_N, CH_R, CH_T, CH_U});
      queue_byte(b, 1'b0);
    end else if (sel < 87) begin
      // non-hex byte inside a \u escape
      queue_byte(CH_BSLASH, 1'b0);
      queue_byte(CH_U, 1'b0);
      queue_hex(16'($urandom_range(0, 16'hFFFF)), $urandom_range(0, 3));
      do b = 8'($urandom_range(0, 255)); while (hex_nibble(b) < 5'd16);
      queue_byte(b, 1'b0);
    end else if (sel == 87) begin
      queue_escape_u(16'hDC00 | 16'($urandom_range(0, 1023)));
    end else if (sel < 90) begin
      queue_escape_u(16'hD800 | 16'($urandom_range(0, 1023)));
      do v = 16'($urandom_range(0, 16'hFFFF)); while (v[15:10] == 6'b110111);
      queue_escape_u(v);
    end else if (sel < 92) begin
      queue_escape_u(16'hD800 | 16'($urandom_range(0, 1023)));
      if ($urandom_range(0, 1) != 0) begin
        do b = 8'($urandom_range(0, 255)); while (b == CH_BSLASH);
      end else begin
        queue_byte(CH_BSLASH, 1'b0);
        do b = 8'($urandom_range(0, 255)); while (b == CH_U);
      end
      queue_byte(b, 1'b0);
    end else begin
      // cut the stream at a random point of an escape
      case ($urandom_range(0, 5))
        0: ;
        1: queue_byte(CH_BSLASH, 1'b0);
        2: begin
          queue_byte(CH_BSLASH, 1'b0);
          queue_byte(CH_U, 1'b0);
          queue_hex(16'($urandom_range(0, 16'hFFFF)), $urandom_range(0, 3));
        end
        3: queue_escape_u(16'hD800 | 16'($urandom_range(0, 1023)));
        4: begin
          queue_escape_u(16'hD800 | 16'($urandom_range(0, 1023)));
          queue_byte(CH_BSLASH, 1'b0);
        end
        default: begin
          queue_escape_u(16'hD800 | 16'($urandom_range(0, 1023)));
          queue_byte(CH_BSLASH, 1'b0);
          queue_byte(CH_U, 1'b0);
          queue_hex(16'hDC00 | 16'($urandom_range(0, 1023)), $urandom_range(0, 3));
        end
      endcase
      queue_byte(8'($urandom_range(0, 255)), 1'b1);
    end
  endtask

  task automatic wait_for_drain();
    while (!(pending_bytes.size() == 0 && !in_ch.valid && exp_words.size() == 0))
      @(posedge clk);
  endtask

  initial begin
    queue_byte(8'h01, 1'b0);
    queue_byte(8'hFF, 1'b0);
    queue_byte(CH_BSLASH, 1'b0);
    queue_byte(CH_N, 1'b0);
    queue_byte(CH_BSLASH, 1'b0);
    queue_byte(8'h78, 1'b0);
    queue_escape_u(16'h20AC);
    queue_escape_u(16'hD83D);
    queue_escape_u(16'hDE00);
    queue_byte(CH_QUOTE, 1'b0);
    queue_byte(8'h00, 1'b1);
    while (!rst_n) @(posedge clk);
    // hold the random part until the directed words are all back
    wait_for_drain();
    while (items_queued < RANDOM_ITEMS + 26) queue_random_sequence();
    wait_for_drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("** json_string_unescape_utf8: PASSED **");
    end else begin
      $display("** json_string_unescape_utf8: FAILED **");
    end
    $finish;
  end

  // --------------------------------------------------------------------------
  // driver: bursts of words with random gaps
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid        <= 1'b0;
      in_ch.in_byte      <= '0;
      in_ch.end_of_input <= 1'b0;
      burst_left = 0;
      gap_left   = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) unescape_step(in_ch.in_byte, in_ch.end_of_input);
      if (!in_ch.valid || in_ch.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_ch.valid <= 1'b0;
        end else if (pending_bytes.size() > 0) begin
          drv_next = pending_bytes.pop_front();
          in_ch.in_byte      <= drv_next.data;
          in_ch.end_of_input <= drv_next.eof;
          in_ch.valid        <= 1'b1;
          if (burst_left > 0) burst_left--;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // receiver ready: rotating stall patterns plus one long hold-off
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      rx_cycle       = 0;
      pattern_left   = 0;
      long_hold_left = 0;
      stall_pattern  = RX_OPEN;
    end else begin
      rx_cycle++;
      if (rx_cycle == LONG_HOLD_START) long_hold_left = LONG_HOLD_CYCLES;
      if (long_hold_left > 0) begin
        long_hold_left--;
        rx_ready = 1'b0;
      end else begin
        if (pattern_left == 0) begin
          stall_pattern = rx_pattern_t'($urandom_range(0, 3));
          pattern_left  = $urandom_range(16, 80);
        end else begin
          pattern_left--;
        end
        case (stall_pattern)
          RX_OPEN:  rx_ready = 1'b1;
          RX_LIGHT: rx_ready = ($urandom_range(0, 3) != 0);
          RX_HEAVY: rx_ready = ($urandom_range(0, 3) == 0);
          default:  rx_ready = (rx_cycle % 3 == 0);
        endcase
      end
      out_ch.ready <= rx_ready;
    end
  end

  // --------------------------------------------------------------------------
  // monitor
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (exp_words.size() == 0) begin
        $error("unexpected word: out_byte %02h kind %0d code %0d last %0b",
               out_ch.out_byte, out_ch.result_kind, out_ch.error_code, out_ch.last);
        mismatch_count++;
      end else begin
        got_exp = exp_words.pop_front();
        if (out_ch.out_byte !== got_exp.data) begin
          $error("out_byte: expected %02h, got %02h", got_exp.data, out_ch.out_byte);
          mismatch_count++;
        end
        if (out_ch.result_kind !== got_exp.kind) begin
          $error("result_kind: expected %0d, got %0d", got_exp.kind, out_ch.result_kind);
          mismatch_count++;
        end
        if (out_ch.error_code !== got_exp.code) begin
          $error("error_code: expected %0d, got %0d", got_exp.code, out_ch.error_code);
          mismatch_count++;
        end
        if (out_ch.last !== got_exp.last) begin
          $error("last: expected %0b, got %0b", got_exp.last, out_ch.last);
          mismatch_count++;
        end
      end
    end
  end

endmodule
